// ===== src/fsp_pkg.sv =====
package fsp_pkg;

    localparam int TILE_ROWS  = 32;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_STRIDE = 64;

    localparam int RW_W    = 13;   // row_width register
    localparam int SR_W    = 7;    // stride registers
    localparam int PITCH_W = 16;
    localparam int ROW_W   = 6;    // patch row / first row
    localparam int PAGE_W  = 32;
    localparam int CNT_W   = 16;   // row count
    localparam int COL_W   = 12;
    localparam int OFS_W   = 21;
    localparam int PSZ_W   = 13;   // stride_rows * stride_cols
    localparam int ORS_W   = 13;   // sticks per output row
    localparam int SPAN_W  = PSZ_W + ORS_W;
    localparam int HELD_W  = ROW_W + SR_W;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRIDE_ROWS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRIDE_COLS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STICK_PITCH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_STICK_LENGTH = 3'd4;
    localparam logic [IDX_W-1:0] REG_FIRST_ROW    = 3'd5;
    localparam logic [IDX_W-1:0] REG_FIRST_PAGE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 3'd7;

    // Clamped and precomputed configuration seen by the step engine
    typedef struct packed {
        logic               busy;
        logic [RW_W-1:0]    width;
        logic [SR_W-1:0]    srows;
        logic [SR_W-1:0]    scols;
        logic [PITCH_W-1:0] pitch;
        logic [PSZ_W-1:0]   psize;
        logic [ORS_W-1:0]   ors;
        logic [SPAN_W-1:0]  span;
        logic [HELD_W-1:0]  held;
        logic [ROW_W-1:0]   first_row;
        logic [PAGE_W-1:0]  first_page;
        logic [CNT_W-1:0]   row_count;
    } t_cfg_view;

    typedef struct packed {
        logic valid;
        logic restart;
    } t_head;

    typedef struct packed {
        logic              stick_valid;
        logic [PAGE_W-1:0] dest_page;
        logic [OFS_W-1:0]  src_byte_offset;
        logic              group_last;
        logic              row_last;
        logic              job_done;
    } t_result;

endpackage

// ===== src/fsp_regs.sv =====
module fsp_regs import fsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg_view         o_cfg
);

    typedef enum logic [3:0] {
        S_PREP = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } t_set_state;

    logic [RW_W-1:0]    r_row_width;
    logic [SR_W-1:0]    r_stride_rows;
    logic [SR_W-1:0]    r_stride_cols;
    logic [PITCH_W-1:0] r_pitch;
    logic [PITCH_W-1:0] r_length;
    logic [ROW_W-1:0]   r_first_row;
    logic [PAGE_W-1:0]  r_first_page;
    logic [CNT_W-1:0]   r_row_count;

    t_set_state         r_state;
    t_set_state         n_state;

    logic [RW_W-1:0]    r_width_c;
    logic [SR_W-1:0]    r_srows_c;
    logic [SR_W-1:0]    r_scols_c;
    logic [RW_W-1:0]    r_dividend;
    logic [SR_W-1:0]    r_rem;
    logic [ORS_W-1:0]   r_quot;
    logic [3:0]         r_step;
    logic [PSZ_W-1:0]   r_psize;
    logic [SPAN_W-1:0]  r_span;
    logic [HELD_W-1:0]  r_held;

    logic               wr;
    logic [IDX_W-1:0]   idx;
    logic [RW_W-1:0]    c_width;
    logic [SR_W-1:0]    c_srows;
    logic [SR_W-1:0]    c_scols;
    logic [SR_W:0]      rem_sh;
    logic               q_bit;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width   <= RW_W'(32);
            r_stride_rows <= SR_W'(2);
            r_stride_cols <= SR_W'(2);
            r_pitch       <= PITCH_W'(64);
            r_length      <= PITCH_W'(64);
            r_first_row   <= '0;
            r_first_page  <= '0;
            r_row_count   <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_ROW_WIDTH:    r_row_width   <= pwdata[RW_W-1:0];
                REG_STRIDE_ROWS:  r_stride_rows <= pwdata[SR_W-1:0];
                REG_STRIDE_COLS:  r_stride_cols <= pwdata[SR_W-1:0];
                REG_STICK_PITCH:  r_pitch       <= pwdata[PITCH_W-1:0];
                REG_STICK_LENGTH: r_length      <= pwdata[PITCH_W-1:0];
                REG_FIRST_ROW:    r_first_row   <= pwdata[ROW_W-1:0];
                REG_FIRST_PAGE:   r_first_page  <= pwdata[PAGE_W-1:0];
                REG_ROW_COUNT:    r_row_count   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ROW_WIDTH:    prdata = DATA_W'(r_row_width);
            REG_STRIDE_ROWS:  prdata = DATA_W'(r_stride_rows);
            REG_STRIDE_COLS:  prdata = DATA_W'(r_stride_cols);
            REG_STICK_PITCH:  prdata = DATA_W'(r_pitch);
            REG_STICK_LENGTH: prdata = DATA_W'(r_length);
            REG_FIRST_ROW:    prdata = DATA_W'(r_first_row);
            REG_FIRST_PAGE:   prdata = DATA_W'(r_first_page);
            REG_ROW_COUNT:    prdata = DATA_W'(r_row_count);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_row_width == '0)                      c_width = RW_W'(1);
        else if (r_row_width > RW_W'(MAX_WIDTH))    c_width = RW_W'(MAX_WIDTH);
        else                                        c_width = r_row_width;
        if (r_stride_rows == '0)                    c_srows = SR_W'(1);
        else if (r_stride_rows > SR_W'(MAX_STRIDE)) c_srows = SR_W'(MAX_STRIDE);
        else                                        c_srows = r_stride_rows;
        if (r_stride_cols == '0)                    c_scols = SR_W'(1);
        else if (r_stride_cols > SR_W'(MAX_STRIDE)) c_scols = SR_W'(MAX_STRIDE);
        else                                        c_scols = r_stride_cols;
    end

    // restoring divider step: width / stride_cols, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dividend[RW_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_scols_c};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_step == 4'(RW_W - 1)) n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  n_state = S_DONE;
            default: n_state = S_PREP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PREP;
        end else if (wr) begin
            r_state <= S_PREP;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_PREP: begin
                r_width_c  <= c_width;
                r_srows_c  <= c_srows;
                r_scols_c  <= c_scols;
                r_dividend <= c_width;
                r_rem      <= '0;
                r_step     <= '0;
            end
            S_DIV: begin
                r_rem        <= q_bit ? SR_W'(rem_sh - {1'b0, r_scols_c}) : rem_sh[SR_W-1:0];
                r_dividend   <= {r_dividend[RW_W-2:0], 1'b0};
                r_quot       <= {r_quot[ORS_W-2:0], q_bit};
                r_step       <= r_step + 4'd1;
                r_psize      <= PSZ_W'(r_srows_c) * PSZ_W'(r_scols_c);
                r_held       <= HELD_W'(r_first_row) * HELD_W'(r_scols_c);
            end
            S_MUL: begin
                r_span <= SPAN_W'(r_psize) * SPAN_W'(r_quot);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        o_cfg.busy       = (r_state != S_DONE);
        o_cfg.width      = r_width_c;
        o_cfg.srows      = r_srows_c;
        o_cfg.scols      = r_scols_c;
        o_cfg.pitch      = r_pitch;
        o_cfg.psize      = r_psize;
        o_cfg.ors        = r_quot;
        o_cfg.span       = r_span;
        o_cfg.held       = r_held;
        o_cfg.first_row  = r_first_row;
        o_cfg.first_page = r_first_page;
        o_cfg.row_count  = r_row_count;
    end

endmodule

// ===== src/fsp_front.sv =====
module fsp_front import fsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  logic  i_restart,
    output logic  o_full,
    input  logic  i_pop,
    output t_head o_head
);

    logic       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr;
    logic       rd;

    assign o_full         = (r_count == 2'd2);
    assign wr             = i_push & ~o_full;
    assign rd             = i_pop & (r_count != 2'd0);
    assign o_head.valid   = (r_count != 2'd0);
    assign o_head.restart = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= ~r_wr_ptr;
            if (rd) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_restart;
    end

endmodule

// ===== src/fsp_back.sv =====
module fsp_back import fsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_view i_cfg,
    input  t_head     i_head,
    input  logic      i_out_ready,
    output logic      o_pop,
    output logic      o_res_valid,
    output t_result   o_res
);

    logic [CNT_W-1:0]  r_rows_left,     n_rows_left,     e_rows_left;
    logic [PAGE_W-1:0] r_row_base,      n_row_base,      e_row_base;
    logic [PAGE_W-1:0] r_patch_base,    n_patch_base,    e_patch_base;
    logic [ROW_W-1:0]  r_patch_row,     n_patch_row,     e_patch_row;
    logic [ROW_W-1:0]  r_srh,           n_srh,           e_srh;
    logic [COL_W-1:0]  r_col_in_row,    n_col_in_row,    e_col_in_row;
    logic [ROW_W-1:0]  r_col_in_stride, n_col_in_stride, e_col_in_stride;
    logic [COL_W-1:0]  r_patch_col,     n_patch_col,     e_patch_col;
    logic [PAGE_W-1:0] r_next_page,     n_next_page,     e_next_page;
    logic [OFS_W-1:0]  r_group_offset,  n_group_offset,  e_group_offset;
    logic [ORS_W-1:0]  r_ors,           n_ors,           e_ors;
    logic [SPAN_W-1:0] r_span,          n_span,          e_span;
    logic [HELD_W-1:0] r_held,          n_held,          e_held;

    logic              go;
    logic              rst_req;
    logic              idle;
    logic              r_last;
    logic              g_last;
    logic              stride_wrap;
    logic              patch_end;
    logic [COL_W-1:0]  pc_inc;
    logic [PAGE_W-1:0] jump_page;
    logic [PAGE_W-1:0] new_patch_base;
    logic [SR_W-1:0]   nr;

    assign go          = i_head.valid & i_out_ready & ~i_cfg.busy;
    assign o_pop       = go;
    assign o_res_valid = go;
    assign rst_req     = i_head.restart;

    // a restart request reloads from config, then produces its stick in the same step
    always_comb begin
        e_rows_left     = rst_req ? i_cfg.row_count  : r_rows_left;
        e_row_base      = rst_req ? i_cfg.first_page : r_row_base;
        e_patch_base    = rst_req ? i_cfg.first_page : r_patch_base;
        e_patch_row     = rst_req ? i_cfg.first_row  : r_patch_row;
        e_srh           = rst_req ? i_cfg.first_row  : r_srh;
        e_col_in_row    = rst_req ? '0               : r_col_in_row;
        e_col_in_stride = rst_req ? '0               : r_col_in_stride;
        e_patch_col     = rst_req ? '0               : r_patch_col;
        e_next_page     = rst_req ? i_cfg.first_page : r_next_page;
        e_group_offset  = rst_req ? '0               : r_group_offset;
        e_ors           = rst_req ? i_cfg.ors        : r_ors;
        e_span          = rst_req ? i_cfg.span       : r_span;
        e_held          = rst_req ? i_cfg.held       : r_held;
    end

    assign idle        = (e_rows_left == '0);
    assign r_last      = ({1'b0, e_col_in_row} == (i_cfg.width - RW_W'(1)));
    assign g_last      = r_last
                         || ((e_col_in_row % COL_W'(TILE_ROWS)) == COL_W'(TILE_ROWS - 1));
    assign stride_wrap = (({1'b0, e_col_in_stride} + SR_W'(1)) == i_cfg.scols);
    assign pc_inc      = e_patch_col + COL_W'(1);
    assign jump_page   = e_row_base + PAGE_W'(pc_inc) * PAGE_W'(i_cfg.psize);
    assign nr          = {1'b0, e_patch_row} + SR_W'(1);
    assign patch_end   = (nr == i_cfg.srows);
    assign new_patch_base = e_patch_base + PAGE_W'(e_span) - PAGE_W'(e_held);

    always_comb begin
        n_rows_left     = e_rows_left;
        n_row_base      = e_row_base;
        n_patch_base    = e_patch_base;
        n_patch_row     = e_patch_row;
        n_srh           = e_srh;
        n_col_in_row    = e_col_in_row;
        n_col_in_stride = e_col_in_stride;
        n_patch_col     = e_patch_col;
        n_next_page     = e_next_page;
        n_group_offset  = e_group_offset;
        n_ors           = e_ors;
        n_span          = e_span;
        n_held          = e_held;
        if (!idle) begin
            n_group_offset  = g_last ? '0 : e_group_offset + OFS_W'(i_cfg.pitch);
            n_next_page     = stride_wrap ? jump_page : e_next_page + PAGE_W'(1);
            n_patch_col     = stride_wrap ? pc_inc : e_patch_col;
            n_col_in_stride = stride_wrap ? '0 : e_col_in_stride + ROW_W'(1);
            n_col_in_row    = e_col_in_row + COL_W'(1);
            if (r_last) begin
                if (patch_end) begin
                    n_patch_base = new_patch_base;
                    n_row_base   = new_patch_base;
                    n_patch_row  = '0;
                    n_srh        = '0;
                    n_held       = '0;
                end else begin
                    n_row_base  = e_row_base + PAGE_W'(i_cfg.scols);
                    n_patch_row = nr[ROW_W-1:0];
                end
                n_rows_left     = e_rows_left - CNT_W'(1);
                n_col_in_row    = '0;
                n_col_in_stride = '0;
                n_patch_col     = '0;
                n_next_page     = n_row_base;
                n_group_offset  = '0;
            end
        end
    end

    always_comb begin
        o_res.stick_valid     = ~idle;
        o_res.dest_page       = idle ? '0 : e_next_page;
        o_res.src_byte_offset = idle ? '0 : e_group_offset;
        o_res.group_last      = ~idle & g_last;
        o_res.row_last        = ~idle & r_last;
        o_res.job_done        = idle | (n_rows_left == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_left     <= '0;
            r_row_base      <= '0;
            r_patch_base    <= '0;
            r_patch_row     <= '0;
            r_srh           <= '0;
            r_col_in_row    <= '0;
            r_col_in_stride <= '0;
            r_patch_col     <= '0;
            r_next_page     <= '0;
            r_group_offset  <= '0;
            r_ors           <= '0;
            r_span          <= '0;
            r_held          <= '0;
        end else if (go) begin
            r_rows_left     <= n_rows_left;
            r_row_base      <= n_row_base;
            r_patch_base    <= n_patch_base;
            r_patch_row     <= n_patch_row;
            r_srh           <= n_srh;
            r_col_in_row    <= n_col_in_row;
            r_col_in_stride <= n_col_in_stride;
            r_patch_col     <= n_patch_col;
            r_next_page     <= n_next_page;
            r_group_offset  <= n_group_offset;
            r_ors           <= n_ors;
            r_span          <= n_span;
            r_held          <= n_held;
        end else if (i_cfg.busy) begin
            // strides may have changed mid-job: refresh products of held state
            r_span <= SPAN_W'(i_cfg.psize) * SPAN_W'(r_ors);
            r_held <= HELD_W'(r_srh) * HELD_W'(i_cfg.scols);
        end
    end

endmodule

// ===== src/fsp_outq.sv =====
module fsp_outq import fsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_ready,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       rd;

    assign o_ready = (r_count != 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign rd      = i_pop & ~o_empty;
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= ~r_wr_ptr;
            if (rd)   r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, i_wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_res;
    end

endmodule

// ===== src/fold_stride_page_index_generator_top.sv =====
// A request is registered in fsp_front, then stepped and registered in fsp_outq before a pop.
// Throughput: one request per cycle (fsp_back's single-cycle stick step) unless fsp_outq is full.
// After reset and after every register write, a setup (stride/width divider and products)
// runs; requests queue meanwhile and are stepped once it finishes.
// Reset is synchronous, active low: registers take their defaults, all job state clears.
module fold_stride_page_index_generator_top import fsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_restart,
    output logic               empty,
    input  logic               pop,
    output logic               o_stick_valid,
    output logic [PAGE_W-1:0]  o_dest_page,
    output logic [OFS_W-1:0]   o_src_byte_offset,
    output logic               o_group_last,
    output logic               o_row_last,
    output logic               o_job_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg_view cfg;
    t_head     head;
    t_result   step_res;
    t_result   out_res;
    logic      head_pop;
    logic      step_valid;
    logic      out_ready;

    fsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_restart (i_restart),
        .o_full    (full),
        .i_pop     (head_pop),
        .o_head    (head)
    );

    fsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_head      (head),
        .i_out_ready (out_ready),
        .o_pop       (head_pop),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    fsp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (step_valid),
        .i_res   (step_res),
        .o_ready (out_ready),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (out_res)
    );

    assign o_stick_valid     = out_res.stick_valid;
    assign o_dest_page       = out_res.dest_page;
    assign o_src_byte_offset = out_res.src_byte_offset;
    assign o_group_last      = out_res.group_last;
    assign o_row_last        = out_res.row_last;
    assign o_job_done        = out_res.job_done;

endmodule

// ===== tb/tb.sv =====
module tb;
    import fsp_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [31:0] OFS_MASK    = (32'd1 << OFS_W) - 1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_restart = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_stick_valid;
    logic [PAGE_W-1:0]  o_dest_page;
    logic [OFS_W-1:0]   o_src_byte_offset;
    logic               o_group_last;
    logic               o_row_last;
    logic               o_job_done;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    fold_stride_page_index_generator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_restart         (i_restart),
        .empty             (empty),
        .pop               (pop),
        .o_stick_valid     (o_stick_valid),
        .o_dest_page       (o_dest_page),
        .o_src_byte_offset (o_src_byte_offset),
        .o_group_last      (o_group_last),
        .o_row_last        (o_row_last),
        .o_job_done        (o_job_done),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // register copy (reset values) and job state of the page index predictor
    logic [31:0] cfg_mirror [8] = '{32'd32, 32'd2, 32'd2, 32'd64, 32'd64, 32'd0, 32'd0, 32'd0};
    logic [31:0] rows_to_go = '0, row_page = '0, patch_page = '0, patch_line = '0;
    logic [31:0] held_line = '0, stick_col = '0, run_col = '0, patch_col = '0;
    logic [31:0] page_ptr = '0, group_ofs = '0, out_sticks = '0;

    bit      stick_reqs [$];
    t_result expected_sticks [$];
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;
    int      quiet_cycles = 0;
    int      fail_count = 0;
    int      phase_no = 0;

    function automatic logic [31:0] clip(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void open_row();
        stick_col = '0;
        run_col   = '0;
        patch_col = '0;
        page_ptr  = row_page;
        group_ofs = '0;
    endfunction

    function automatic t_result fold_step(logic restart);
        logic [31:0] width, srows, scols, psize, nr;
        logic        r_last, g_last;
        t_result     res;
        width = clip(cfg_mirror[REG_ROW_WIDTH], 1, MAX_WIDTH);
        srows = clip(cfg_mirror[REG_STRIDE_ROWS], 1, MAX_STRIDE);
        scols = clip(cfg_mirror[REG_STRIDE_COLS], 1, MAX_STRIDE);
        psize = srows * scols;
        res = '0;
        if (restart) begin
            rows_to_go = cfg_mirror[REG_ROW_COUNT];
            row_page   = cfg_mirror[REG_FIRST_PAGE];
            patch_page = cfg_mirror[REG_FIRST_PAGE];
            patch_line = cfg_mirror[REG_FIRST_ROW];
            held_line  = cfg_mirror[REG_FIRST_ROW];
            out_sticks = width / scols;
            open_row();
        end
        if (rows_to_go == 0) begin
            res.job_done = 1'b1;
            return res;
        end
        r_last = (stick_col == width - 1);
        g_last = r_last || (stick_col % TILE_ROWS == TILE_ROWS - 1);
        res.stick_valid     = 1'b1;
        res.dest_page       = page_ptr;
        res.src_byte_offset = group_ofs[OFS_W-1:0];
        res.group_last      = g_last;
        res.row_last        = r_last;

        group_ofs = g_last ? '0 : ((group_ofs + cfg_mirror[REG_STICK_PITCH]) & OFS_MASK);
        page_ptr  = page_ptr + 1;
        if (run_col + 1 == scols) begin
            // end of a stride run: jump to the next patch column
            patch_col = (patch_col + 1) & 32'hFFF;
            page_ptr  = row_page + patch_col * psize;
            run_col   = '0;
        end else begin
            run_col = (run_col + 1) & 32'h3F;
        end
        stick_col = (stick_col + 1) & 32'hFFF;

        if (r_last) begin
            nr = patch_line + 1;
            if (nr == srows) begin
                patch_page = patch_page + psize * out_sticks - held_line * scols;
                row_page   = patch_page;
                patch_line = '0;
                held_line  = '0;
            end else begin
                row_page   = row_page + scols;
                patch_line = nr & 32'h3F;
            end
            rows_to_go = (rows_to_go - 1) & 32'hFFFF;
            open_row();
        end
        res.job_done = (rows_to_go == 0);
        return res;
    endfunction

    // request side: predict each stick as it is put on the port, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (stick_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                logic nxt;
                nxt = stick_reqs[0];
                stick_reqs.delete(0);
                expected_sticks.push_back(fold_step(nxt));
                push      <= 1'b1;
                i_restart <= nxt;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                t_result got, want;
                got.stick_valid     = o_stick_valid;
                got.dest_page       = o_dest_page;
                got.src_byte_offset = o_src_byte_offset;
                got.group_last      = o_group_last;
                got.row_last        = o_row_last;
                got.job_done        = o_job_done;
                if (expected_sticks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: v=%0b page=%h ofs=%h gl=%0b rl=%0b done=%0b",
                                 got.stick_valid, got.dest_page, got.src_byte_offset,
                                 got.group_last, got.row_last, got.job_done);
                end else begin
                    want = expected_sticks[0];
                    expected_sticks.delete(0);
                    if (got.stick_valid !== want.stick_valid || got.dest_page !== want.dest_page
                        || got.src_byte_offset !== want.src_byte_offset
                        || got.group_last !== want.group_last
                        || got.row_last !== want.row_last || got.job_done !== want.job_done) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: want v=%0b page=%h ofs=%h gl=%0b rl=%0b done=%0b",
                                     want.stick_valid, want.dest_page, want.src_byte_offset,
                                     want.group_last, want.row_last, want.job_done);
                            $display("          got  v=%0b page=%h ofs=%h gl=%0b rl=%0b done=%0b",
                                     got.stick_valid, got.dest_page, got.src_byte_offset,
                                     got.group_last, got.row_last, got.job_done);
                        end
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                pop         <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("** fold_stride_page_index_generator_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        int bits;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_WIDTH:                    bits = RW_W;
            REG_STRIDE_ROWS, REG_STRIDE_COLS: bits = SR_W;
            REG_STICK_PITCH, REG_STICK_LENGTH: bits = PITCH_W;
            REG_FIRST_ROW:                    bits = ROW_W;
            REG_FIRST_PAGE:                   bits = PAGE_W;
            default:                          bits = CNT_W;
        endcase
        cfg_mirror[idx] = value & 32'((64'd1 << bits) - 1);
    endtask

    // wait for the block to go idle, then pick the idling pattern for the next phase
    task automatic begin_phase();
        do @(negedge i_clk);
        while (stick_reqs.size() != 0 || expected_sticks.size() != 0 || push);
        case (phase_no % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 48; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 48; end
            default: begin send_gap_pct = 26; recv_stall_pct = 26; end
        endcase
        phase_no++;
    endtask

    task automatic feed(int unsigned count, int unsigned noise_pct, bit lead);
        @(negedge i_clk);
        stick_reqs.push_back(lead);
        repeat (count - 1) stick_reqs.push_back($urandom_range(99) < noise_pct);
    endtask

    initial begin
        int unsigned sent, w, sr, sc, rc, fr, r, n, items;
        bit          noisy;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no job loaded yet: idle results
        begin_phase();
        feed(2, 0, 1'b0);
        // restart with zero rows
        begin_phase();
        feed(1, 0, 1'b1);

        begin_phase();
        write_reg(REG_ROW_WIDTH, 5);
        write_reg(REG_STRIDE_ROWS, 2);
        write_reg(REG_STRIDE_COLS, 2);
        write_reg(REG_STICK_PITCH, 16'hFFFF);
        write_reg(REG_STICK_LENGTH, 16'hFFFF);
        write_reg(REG_FIRST_ROW, 1);
        write_reg(REG_FIRST_PAGE, 32'hFFFF_FFF0);
        write_reg(REG_ROW_COUNT, 2);
        feed(12, 0, 1'b1);

        // zero width and strides, start row far above the stride
        begin_phase();
        write_reg(REG_ROW_WIDTH, 0);
        write_reg(REG_STRIDE_ROWS, 0);
        write_reg(REG_STRIDE_COLS, 0);
        write_reg(REG_STICK_PITCH, 0);
        write_reg(REG_STICK_LENGTH, 0);
        write_reg(REG_FIRST_ROW, 63);
        write_reg(REG_FIRST_PAGE, 0);
        feed(4, 0, 1'b1);

        // receiver holds off while the sender keeps offering
        begin_phase();
        write_reg(REG_ROW_WIDTH, 16);
        write_reg(REG_STRIDE_ROWS, 3);
        write_reg(REG_STRIDE_COLS, 4);
        write_reg(REG_STICK_PITCH, 64);
        write_reg(REG_FIRST_ROW, 0);
        write_reg(REG_FIRST_PAGE, $urandom());
        write_reg(REG_ROW_COUNT, 20);
        feed(321, 0, 1'b1);
        hold_cycles = 400;

        // strides above the maximum, longest job
        begin_phase();
        write_reg(REG_ROW_WIDTH, 130);
        write_reg(REG_STRIDE_ROWS, 127);
        write_reg(REG_STRIDE_COLS, 127);
        write_reg(REG_ROW_COUNT, 16'hFFFF);
        feed(6, 0, 1'b1);

        sent = 0;
        while (sent < 700) begin
            begin_phase();
            w  = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(40, 1);
            sr = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(6, 1);
            sc = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(6, 1);
            r  = $urandom_range(19);
            rc = (r < 2) ? 0 : (r == 2) ? $urandom_range(65535) : $urandom_range(5, 1);
            fr = ($urandom_range(4) == 0) ? $urandom_range(63)
                                          : $urandom_range(clip(sr, 1, MAX_STRIDE) - 1, 0);
            if ($urandom_range(4) != 0) write_reg(REG_ROW_WIDTH, w);
            if ($urandom_range(4) != 0) write_reg(REG_STRIDE_ROWS, sr);
            if ($urandom_range(4) != 0) write_reg(REG_STRIDE_COLS, sc);
            if ($urandom_range(4) != 0)
                write_reg(REG_STICK_PITCH, $urandom_range(1) ? $urandom_range(65535)
                                                             : $urandom_range(256, 1));
            if ($urandom_range(4) == 0) write_reg(REG_STICK_LENGTH, $urandom_range(65535));
            if ($urandom_range(4) != 0) write_reg(REG_FIRST_ROW, fr);
            if ($urandom_range(4) != 0) write_reg(REG_FIRST_PAGE, $urandom());
            if ($urandom_range(4) != 0) write_reg(REG_ROW_COUNT, rc);
            n = clip(cfg_mirror[REG_ROW_WIDTH], 1, MAX_WIDTH) * cfg_mirror[REG_ROW_COUNT];
            items = (n <= 100) ? n + $urandom_range(4, 1) : $urandom_range(100, 30);
            noisy = ($urandom_range(4) == 0);
            feed(items, noisy ? 5 : 0, $urandom_range(9) != 0);
            sent += items;
        end

        // full-width row, then a width cut below the current column mid-row
        begin_phase();
        write_reg(REG_ROW_WIDTH, 8191);
        write_reg(REG_STRIDE_ROWS, 1);
        write_reg(REG_STRIDE_COLS, 64);
        write_reg(REG_FIRST_ROW, 0);
        write_reg(REG_ROW_COUNT, 3);
        feed(70, 0, 1'b1);
        begin_phase();
        write_reg(REG_ROW_WIDTH, 5);
        feed(20, 0, 1'b0);

        begin_phase();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** fold_stride_page_index_generator_top: PASSED **");
        end else begin
            $display("** fold_stride_page_index_generator_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fsp_pkg.sv
src/fsp_regs.sv
src/fsp_front.sv
src/fsp_back.sv
src/fsp_outq.sv
src/fold_stride_page_index_generator_top.sv
tb/tb.sv
